/* sv/pcbs_pkg.sv */
// ----------------------------------------------------------------------------
// pcbs_pkg
// Shared constants, counter store map and interface types of the binned
// point statistics block.
// ----------------------------------------------------------------------------
package pcbs_pkg;

  localparam int unsigned Z_BINS         = 1024;
  localparam int unsigned INTENSITY_BINS = 1024;
  localparam int unsigned COUNT_WIDTH    = 40;
  localparam int unsigned READ_WIDTH     = 40;

  // Layout of the single counter store: totals, per return, per class,
  // elevation histogram, intensity histogram.
  localparam int unsigned TOT_BASE   = 0;
  localparam int unsigned RET_BASE   = TOT_BASE + 4;
  localparam int unsigned CLS_BASE   = RET_BASE + 16;
  localparam int unsigned ZH_BASE    = CLS_BASE + 256;
  localparam int unsigned IH_BASE    = ZH_BASE + Z_BINS;
  localparam int unsigned DEPTH      = IH_BASE + INTENSITY_BINS;
  localparam int unsigned ADDR_WIDTH = $clog2(DEPTH);
  localparam int unsigned ZIDX_WIDTH = $clog2(Z_BINS);

  // Offsets inside the totals group.
  localparam logic [1:0] TOT_POINTS = 2'd0;
  localparam logic [1:0] TOT_SINGLE = 2'd1;
  localparam logic [1:0] TOT_Z_OOR  = 2'd2;
  localparam logic [1:0] TOT_I_OOR  = 2'd3;

  // Divider geometry: numerator 2*mag+w, denominator 2*w.
  localparam int unsigned DIV_NUM_WIDTH = 34;
  localparam int unsigned DIV_DEN_WIDTH = 21;
  localparam int unsigned DIV_CNT_WIDTH = $clog2(DIV_NUM_WIDTH + 1);
  localparam int unsigned Z_DIV_STEPS   = 34;
  localparam int unsigned I_DIV_STEPS   = 18;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [2:0] TBL_TOTALS = 3'd0;
  localparam logic [2:0] TBL_RETURN = 3'd1;
  localparam logic [2:0] TBL_CLASS  = 3'd2;
  localparam logic [2:0] TBL_ZHIST  = 3'd3;
  localparam logic [2:0] TBL_IHIST  = 3'd4;

  localparam int unsigned CFG_INDEX_WIDTH = 2;
  localparam int unsigned CFG_DATA_WIDTH  = 32;
  localparam logic [1:0] CFG_Z_WIDTH = 2'd0;
  localparam logic [1:0] CFG_I_WIDTH = 2'd1;
  localparam logic [1:0] CFG_Z_FIRST = 2'd2;

  typedef logic [ADDR_WIDTH-1:0]  addr_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic  valid;
    logic  bump;
    addr_t addr;
  } cnt_cmd_t;

  typedef struct packed {
    logic   ready;
    logic   done;
    count_t rdata;
  } cnt_rsp_t;

endpackage

/* sv/pcbs_div.sv */
// ----------------------------------------------------------------------------
// pcbs_div
// Bit-serial restoring divider, one quotient bit per cycle, shared by the
// elevation and intensity binning.
// ----------------------------------------------------------------------------
module pcbs_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [pcbs_pkg::DIV_NUM_WIDTH-1:0]    num_i,
  input  logic [pcbs_pkg::DIV_DEN_WIDTH-1:0]    den_i,
  input  logic [pcbs_pkg::DIV_CNT_WIDTH-1:0]    steps_i,
  output logic                                  done_o,
  output logic [pcbs_pkg::DIV_NUM_WIDTH-1:0]    quot_o
);
  import pcbs_pkg::*;

  logic                     busy_q;
  logic                     done_q;
  logic [DIV_CNT_WIDTH-1:0] cnt_q;
  logic [DIV_NUM_WIDTH-1:0] n_q;
  logic [DIV_NUM_WIDTH-1:0] q_q;
  logic [DIV_DEN_WIDTH-1:0] r_q;
  logic [DIV_DEN_WIDTH-1:0] d_q;
  logic [DIV_DEN_WIDTH:0]   r_sh;
  logic [DIV_DEN_WIDTH:0]   trial;
  logic                     ge;
  logic                     last;

  always_comb begin
    r_sh  = {r_q, n_q[DIV_NUM_WIDTH-1]};
    trial = r_sh - {1'b0, d_q};
    ge    = ~trial[DIV_DEN_WIDTH];
    last  = busy_q && (cnt_q == DIV_CNT_WIDTH'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= last;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_WIDTH'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // The remainder stays below the divisor, so it always fits its width.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      n_q <= num_i;
      d_q <= den_i;
      r_q <= '0;
      q_q <= '0;
    end else if (busy_q) begin
      n_q <= {n_q[DIV_NUM_WIDTH-2:0], 1'b0};
      r_q <= ge ? trial[DIV_DEN_WIDTH-1:0] : r_sh[DIV_DEN_WIDTH-1:0];
      q_q <= {q_q[DIV_NUM_WIDTH-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

/* sv/pcbs_counters.sv */
// ----------------------------------------------------------------------------
// pcbs_counters
// Counter store: one memory holding every counter, a shared incrementer for
// read-modify-write bumps, and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module pcbs_counters (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pcbs_pkg::cnt_cmd_t cmd_i,
  output pcbs_pkg::cnt_rsp_t rsp_o
);
  import pcbs_pkg::*;

  count_t mem_q [DEPTH];
  count_t rdata_q;
  addr_t  addr_q;
  logic   bump_q;
  logic   busy_q;
  logic   clr_q;
  logic   clr_d;
  addr_t  clr_addr_q;
  addr_t  clr_addr_d;
  logic   accept;
  logic   we;
  addr_t  waddr;
  count_t wdata;

  assign accept = cmd_i.valid && !clr_q && !busy_q;

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + addr_t'(1);
      if (clr_addr_q == addr_t'(DEPTH - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  // Write port: the clearing sweep, or the write-back of a registered bump.
  always_comb begin
    we    = 1'b0;
    waddr = addr_q;
    wdata = rdata_q + count_t'(1);
    if (clr_q) begin
      we    = 1'b1;
      waddr = clr_addr_q;
      wdata = '0;
    end else if (busy_q && bump_q) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      busy_q     <= 1'b0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
      busy_q     <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (accept) begin
      rdata_q <= mem_q[cmd_i.addr];
      addr_q  <= cmd_i.addr;
      bump_q  <= cmd_i.bump;
    end
  end

  assign rsp_o.ready = !clr_q && !busy_q;
  assign rsp_o.done  = busy_q;
  assign rsp_o.rdata = rdata_q;

endmodule

/* sv/point_cloud_binned_statistics_top.sv */
// ----------------------------------------------------------------------------
// point_cloud_binned_statistics_top
// Per-point statistics: totals, per-return and per-class counts, and
// elevation and intensity histograms with rounded binning.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i / in_ready_o) carries one add or read item
// per transfer; the output channel (out_valid_o / out_ready_i) returns one
// result per item, in order. Configuration writes go through cfg_we_i,
// cfg_index_i and cfg_data_i and take effect at once; write them only while
// the block is idle.
// A kept add item goes through a decode state, 34 divider steps on the
// elevation and 18 on the intensity, each followed by the hand-over of the
// quotient, a range check state, up to six read-modify-write bumps (five
// when the point is not single-return) through the shared counter store,
// and the load of the output register. A dropped point goes from decode to
// the output register, and a read item waits for its counter unless its
// index is past its table. The next item is taken only once the result is
// loaded, so the block takes no item before it is through with the last.
// After reset all 2324 counters are cleared by a sweep, one entry per cycle;
// in_ready_o stays low during the sweep. A finished result waits in the
// output register while the next item is taken in; if the receiver still
// stalls when that item is done, the block holds it and stays busy.
// ----------------------------------------------------------------------------
module point_cloud_binned_statistics_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [pcbs_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index_i,
  input  logic [pcbs_pkg::CFG_DATA_WIDTH-1:0]    cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   operation_i,
  input  logic                                   withheld_i,
  input  logic                                   rejected_i,
  input  logic                                   in_buffer_i,
  input  logic [3:0]                             return_number_i,
  input  logic [3:0]                             number_of_returns_i,
  input  logic [7:0]                             classification_i,
  input  logic signed [31:0]                     z_mm_i,
  input  logic [15:0]                            intensity_i,
  input  logic [2:0]                             read_table_i,
  input  logic [9:0]                             read_index_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   counted_o,
  output logic signed [31:0]                     z_bin_o,
  output logic [15:0]                            intensity_bin_o,
  output logic                                   z_out_of_range_o,
  output logic                                   intensity_out_of_range_o,
  output logic [pcbs_pkg::READ_WIDTH-1:0]        read_value_o
);
  import pcbs_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_DECODE    = 9'b000000010,
    S_RD_WAIT   = 9'b000000100,
    S_Z_DIV     = 9'b000001000,
    S_I_DIV     = 9'b000010000,
    S_CHECK     = 9'b000100000,
    S_BUMP      = 9'b001000000,
    S_BUMP_WAIT = 9'b010000000,
    S_FINISH    = 9'b100000000
  } state_e;

  typedef enum logic [2:0] {
    B_TOTAL  = 3'd0,
    B_RETURN = 3'd1,
    B_CLASS  = 3'd2,
    B_SINGLE = 3'd3,
    B_ZHIST  = 3'd4,
    B_IHIST  = 3'd5
  } bump_e;

  state_e state_q, state_d;
  bump_e  bump_q, bump_d;

  // Configuration.
  logic [19:0]        zw_q;
  logic [15:0]        iw_q;
  logic signed [31:0] zfirst_q;

  // Captured item.
  logic        op_q;
  logic        drop_q;
  logic [3:0]  ret_q;
  logic [3:0]  nret_q;
  logic [7:0]  cls_q;
  logic [31:0] z_q;
  logic [15:0] inten_q;
  logic [2:0]  tbl_q;
  logic [9:0]  idx_q;

  // Working results.
  logic                  counted_q;
  logic signed [31:0]    zbin_q;
  logic [15:0]           ibin_q;
  logic                  zoor_q;
  logic                  ioor_q;
  logic [READ_WIDTH-1:0] rval_q;
  addr_t                 zaddr_q;
  addr_t                 iaddr_q;

  // Output register.
  logic                  out_valid_q;
  logic                  out_counted_q;
  logic signed [31:0]    out_zbin_q;
  logic [15:0]           out_ibin_q;
  logic                  out_zoor_q;
  logic                  out_ioor_q;
  logic [READ_WIDTH-1:0] out_rval_q;

  logic                     accept;
  logic                     out_load;
  logic [19:0]              zw_eff;
  logic [15:0]              iw_eff;
  logic [31:0]              zmag;
  logic [17:0]              i_num_lo;
  logic                     div_start;
  logic [DIV_NUM_WIDTH-1:0] div_num;
  logic [DIV_DEN_WIDTH-1:0] div_den;
  logic [DIV_CNT_WIDTH-1:0] div_steps;
  logic                     div_done;
  logic [DIV_NUM_WIDTH-1:0] div_quot;
  logic                     rd_hit;
  addr_t                    rd_addr;
  logic [33:0]              zidx;
  logic                     zoor;
  logic                     ioor;
  logic                     bump_apply;
  addr_t                    bump_addr;
  cnt_cmd_t                 cmd;
  cnt_rsp_t                 rsp;

  assign in_ready_o = (state_q == S_IDLE) && rsp.ready;
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);

  // A width register holding zero acts as width one.
  assign zw_eff   = (zw_q == 20'd0) ? 20'd1 : zw_q;
  assign iw_eff   = (iw_q == 16'd0) ? 16'd1 : iw_q;
  assign zmag     = z_q[31] ? (~z_q + 32'd1) : z_q;
  assign i_num_lo = {1'b0, inten_q, 1'b0} + 18'(iw_eff);

  // Read address decode; indexes beyond a table read as zero.
  always_comb begin
    rd_hit  = 1'b0;
    rd_addr = addr_t'(TOT_BASE);
    unique case (tbl_q)
      TBL_TOTALS: begin
        rd_hit  = idx_q < 10'd4;
        rd_addr = addr_t'(TOT_BASE) + addr_t'(idx_q[1:0]);
      end
      TBL_RETURN: begin
        rd_hit  = idx_q < 10'd16;
        rd_addr = addr_t'(RET_BASE) + addr_t'(idx_q[3:0]);
      end
      TBL_CLASS: begin
        rd_hit  = idx_q < 10'd256;
        rd_addr = addr_t'(CLS_BASE) + addr_t'(idx_q[7:0]);
      end
      TBL_ZHIST: begin
        rd_hit  = {22'd0, idx_q} < 32'(Z_BINS);
        rd_addr = addr_t'(ZH_BASE) + addr_t'(idx_q);
      end
      TBL_IHIST: begin
        rd_hit  = {22'd0, idx_q} < 32'(INTENSITY_BINS);
        rd_addr = addr_t'(IH_BASE) + addr_t'(idx_q);
      end
      default: begin
        rd_hit = 1'b0;
      end
    endcase
  end

  // Table position of the elevation bin, and range checks.
  always_comb begin
    zidx = {{2{zbin_q[31]}}, zbin_q} - {{2{zfirst_q[31]}}, zfirst_q};
    zoor = zidx[33] || (zidx >= 34'(Z_BINS));
    ioor = {1'b0, ibin_q} >= 17'(INTENSITY_BINS);
  end

  always_comb begin
    bump_apply = 1'b1;
    bump_addr  = addr_t'(TOT_BASE) + addr_t'(TOT_POINTS);
    unique case (bump_q)
      B_TOTAL:  bump_addr = addr_t'(TOT_BASE) + addr_t'(TOT_POINTS);
      B_RETURN: bump_addr = addr_t'(RET_BASE) + addr_t'(ret_q);
      B_CLASS:  bump_addr = addr_t'(CLS_BASE) + addr_t'(cls_q);
      B_SINGLE: begin
        bump_apply = nret_q == 4'd1;
        bump_addr  = addr_t'(TOT_BASE) + addr_t'(TOT_SINGLE);
      end
      B_ZHIST:  bump_addr = zoor_q ? addr_t'(TOT_BASE) + addr_t'(TOT_Z_OOR) : zaddr_q;
      B_IHIST:  bump_addr = ioor_q ? addr_t'(TOT_BASE) + addr_t'(TOT_I_OOR) : iaddr_q;
      default:  bump_apply = 1'b0;
    endcase
  end

  // Divider and counter store requests.
  always_comb begin
    div_start = 1'b0;
    div_num   = {1'b0, zmag, 1'b0} + DIV_NUM_WIDTH'(zw_eff);
    div_den   = {zw_eff, 1'b0};
    div_steps = DIV_CNT_WIDTH'(Z_DIV_STEPS);
    cmd.valid = 1'b0;
    cmd.bump  = 1'b0;
    cmd.addr  = rd_addr;
    if (state_q == S_DECODE) begin
      if (op_q == OP_READ) begin
        cmd.valid = rd_hit;
      end else begin
        div_start = !drop_q;
      end
    end else if (state_q == S_Z_DIV) begin
      // The intensity numerator is aligned to the top so only its bits are stepped.
      div_start = div_done;
      div_num   = {i_num_lo, 16'd0};
      div_den   = {4'd0, iw_eff, 1'b0};
      div_steps = DIV_CNT_WIDTH'(I_DIV_STEPS);
    end else if (state_q == S_BUMP) begin
      cmd.valid = bump_apply;
      cmd.bump  = 1'b1;
      cmd.addr  = bump_addr;
    end
  end

  always_comb begin
    state_d = state_q;
    bump_d  = bump_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (op_q == OP_READ) begin
          state_d = rd_hit ? S_RD_WAIT : S_FINISH;
        end else begin
          state_d = drop_q ? S_FINISH : S_Z_DIV;
        end
      end
      S_RD_WAIT: begin
        if (rsp.done) state_d = S_FINISH;
      end
      S_Z_DIV: begin
        if (div_done) state_d = S_I_DIV;
      end
      S_I_DIV: begin
        if (div_done) state_d = S_CHECK;
      end
      S_CHECK: begin
        bump_d  = B_TOTAL;
        state_d = S_BUMP;
      end
      S_BUMP: begin
        if (bump_apply) begin
          state_d = S_BUMP_WAIT;
        end else if (bump_q == B_IHIST) begin
          state_d = S_FINISH;
        end else begin
          bump_d = bump_e'(bump_q + 3'd1);
        end
      end
      S_BUMP_WAIT: begin
        if (rsp.done) begin
          if (bump_q == B_IHIST) begin
            state_d = S_FINISH;
          end else begin
            bump_d  = bump_e'(bump_q + 3'd1);
            state_d = S_BUMP;
          end
        end
      end
      S_FINISH: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bump_q      <= B_TOTAL;
      out_valid_q <= 1'b0;
      zw_q        <= 20'd2000;
      iw_q        <= 16'd50;
      zfirst_q    <= 32'sd0;
    end else begin
      state_q <= state_d;
      bump_q  <= bump_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_Z_WIDTH: zw_q     <= cfg_data_i[19:0];
          CFG_I_WIDTH: iw_q     <= cfg_data_i[15:0];
          CFG_Z_FIRST: zfirst_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= operation_i;
      drop_q  <= withheld_i | rejected_i | in_buffer_i;
      ret_q   <= return_number_i;
      nret_q  <= number_of_returns_i;
      cls_q   <= classification_i;
      z_q     <= z_mm_i;
      inten_q <= intensity_i;
      tbl_q   <= read_table_i;
      idx_q   <= read_index_i;
    end
    if (state_q == S_DECODE) begin
      counted_q <= 1'b0;
      zbin_q    <= '0;
      ibin_q    <= '0;
      zoor_q    <= 1'b0;
      ioor_q    <= 1'b0;
      rval_q    <= '0;
    end
    if ((state_q == S_RD_WAIT) && rsp.done) begin
      rval_q <= READ_WIDTH'(rsp.rdata);
    end
    if ((state_q == S_Z_DIV) && div_done) begin
      zbin_q <= z_q[31] ? (~div_quot[31:0] + 32'd1) : div_quot[31:0];
    end
    if ((state_q == S_I_DIV) && div_done) begin
      ibin_q <= div_quot[15:0];
    end
    if (state_q == S_CHECK) begin
      counted_q <= 1'b1;
      zoor_q    <= zoor;
      ioor_q    <= ioor;
      zaddr_q   <= addr_t'(ZH_BASE) + addr_t'(zidx[ZIDX_WIDTH-1:0]);
      iaddr_q   <= addr_t'(IH_BASE) + addr_t'(ibin_q);
    end
    if (out_load) begin
      out_counted_q <= counted_q;
      out_zbin_q    <= zbin_q;
      out_ibin_q    <= ibin_q;
      out_zoor_q    <= zoor_q;
      out_ioor_q    <= ioor_q;
      out_rval_q    <= rval_q;
    end
  end

  pcbs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .steps_i (div_steps),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  pcbs_counters u_counters (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rsp_o  (rsp)
  );

  assign out_valid_o              = out_valid_q;
  assign counted_o                = out_counted_q;
  assign z_bin_o                  = out_zbin_q;
  assign intensity_bin_o          = out_ibin_q;
  assign z_out_of_range_o         = out_zoor_q;
  assign intensity_out_of_range_o = out_ioor_q;
  assign read_value_o             = out_rval_q;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the binned point statistics block. Points and
// counter reads go in over a valid/ready channel, and each result is compared
// with a local model of the counters and the rounded binning. The run covers
// several bin width and first-bin settings, with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import pcbs_pkg::*;

  localparam logic [2:0] TBL_UNMAPPED = 3'd7;
  localparam logic [9:0] TOT_PAST_END = 10'd4;
  localparam int unsigned RUN_ITEMS   = 100;
  localparam int unsigned PHASES      = 6;

  typedef struct packed {
    logic               op;
    logic               withheld;
    logic               rejected;
    logic               in_buffer;
    logic [3:0]         ret_num;
    logic [3:0]         num_rets;
    logic [7:0]         cls;
    logic signed [31:0] z_mm;
    logic [15:0]        inten;
    logic [2:0]         tbl;
    logic [9:0]         idx;
  } point_t;

  typedef struct packed {
    logic                  counted;
    logic signed [31:0]    z_bin;
    logic [15:0]           i_bin;
    logic                  z_oor;
    logic                  i_oor;
    logic [READ_WIDTH-1:0] value;
  } stats_out_t;

  typedef struct packed {
    point_t     pt;
    logic       typed;
    stats_out_t want;
  } dir_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index_i = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic                       operation_i = OP_ADD;
  logic                       withheld_i = 1'b0;
  logic                       rejected_i = 1'b0;
  logic                       in_buffer_i = 1'b0;
  logic [3:0]                 return_number_i = '0;
  logic [3:0]                 number_of_returns_i = '0;
  logic [7:0]                 classification_i = '0;
  logic signed [31:0]         z_mm_i = '0;
  logic [15:0]                intensity_i = '0;
  logic [2:0]                 read_table_i = TBL_TOTALS;
  logic [9:0]                 read_index_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic                       counted_o;
  logic signed [31:0]         z_bin_o;
  logic [15:0]                intensity_bin_o;
  logic                       z_out_of_range_o;
  logic                       intensity_out_of_range_o;
  logic [READ_WIDTH-1:0]      read_value_o;

  point_cloud_binned_statistics_top dut (.*);

  // Local copy of the block's configuration and counters.
  logic [19:0]        zbin_width = 20'd2000;
  logic [15:0]        ibin_width = 16'd50;
  logic signed [31:0] zfirst = '0;
  count_t             points_total = '0;
  count_t             single_total = '0;
  count_t             z_oor_total = '0;
  count_t             i_oor_total = '0;
  count_t             ret_tally [16] = '{default: '0};
  count_t             cls_tally [256] = '{default: '0};
  count_t             zhist_tally [Z_BINS] = '{default: '0};
  count_t             ihist_tally [INTENSITY_BINS] = '{default: '0};
  int                 last_zidx = 0;
  int                 last_ibin = 0;

  stats_out_t stats_due [$];
  int         mismatch_count = 0;
  logic       quiet = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [63:0] round_half_up(input logic [63:0] mag, input logic [63:0] w);
    return (2 * mag + w) / (2 * w);
  endfunction

  function automatic count_t counter_value(input logic [2:0] tbl, input logic [9:0] idx);
    case (tbl)
      TBL_TOTALS: begin
        if (idx == TOT_POINTS) return points_total;
        if (idx == TOT_SINGLE) return single_total;
        if (idx == TOT_Z_OOR) return z_oor_total;
        if (idx == TOT_I_OOR) return i_oor_total;
        return '0;
      end
      TBL_RETURN: return (idx < 16) ? ret_tally[idx[3:0]] : '0;
      TBL_CLASS:  return (idx < 256) ? cls_tally[idx[7:0]] : '0;
      TBL_ZHIST:  return (idx < Z_BINS) ? zhist_tally[idx] : '0;
      TBL_IHIST:  return (idx < INTENSITY_BINS) ? ihist_tally[idx] : '0;
      default:    return '0;
    endcase
  endfunction

  // Works out the result of a point or read; kept points update the counters.
  function automatic stats_out_t tally_point(input point_t p);
    stats_out_t  r;
    logic [63:0] zw, iw, zmag, qmag, ibin;
    longint      zl, zbin, zidx;
    logic        zoor, ioor;
    r = '0;
    if (p.op == OP_READ) begin
      r.value = counter_value(p.tbl, p.idx);
      return r;
    end
    if (p.withheld || p.rejected || p.in_buffer) return r;
    zw   = (zbin_width == 0) ? 64'd1 : 64'(zbin_width);
    iw   = (ibin_width == 0) ? 64'd1 : 64'(ibin_width);
    zl   = $signed(p.z_mm);
    zmag = (zl < 0) ? -zl : zl;
    qmag = round_half_up(zmag, zw);
    zbin = (zl < 0) ? -longint'(qmag) : longint'(qmag);
    ibin = round_half_up(64'(p.inten), iw);
    zidx = zbin - longint'(zfirst);
    zoor = (zidx < 0) || (zidx >= longint'(Z_BINS));
    ioor = ibin >= INTENSITY_BINS;

    points_total++;
    ret_tally[p.ret_num]++;
    cls_tally[p.cls]++;
    if (p.num_rets == 4'd1) single_total++;
    if (zoor) begin
      z_oor_total++;
    end else begin
      zhist_tally[zidx]++;
      last_zidx = int'(zidx);
    end
    if (ioor) begin
      i_oor_total++;
    end else begin
      ihist_tally[ibin]++;
      last_ibin = int'(ibin);
    end

    r.counted = 1'b1;
    r.z_bin   = 32'(zbin);
    r.i_bin   = 16'(ibin);
    r.z_oor   = zoor;
    r.i_oor   = ioor;
    return r;
  endfunction

  function automatic point_t add_pt(input logic w, input logic rj, input logic b,
                                    input logic [3:0] rn, input logic [3:0] nr,
                                    input logic [7:0] c, input logic signed [31:0] z,
                                    input logic [15:0] i);
    point_t p;
    p = '0;
    p.op = OP_ADD;
    {p.withheld, p.rejected, p.in_buffer} = {w, rj, b};
    {p.ret_num, p.num_rets, p.cls, p.z_mm, p.inten} = {rn, nr, c, z, i};
    return p;
  endfunction

  function automatic point_t read_pt(input logic [2:0] tbl, input logic [9:0] idx);
    point_t p;
    p = '0;
    p.op  = OP_READ;
    p.tbl = tbl;
    p.idx = idx;
    return p;
  endfunction

  function automatic stats_out_t kept(input logic signed [31:0] zb, input logic [15:0] ib,
                                      input logic zo, input logic io);
    stats_out_t r;
    r = '0;
    r.counted = 1'b1;
    r.z_bin   = zb;
    r.i_bin   = ib;
    r.z_oor   = zo;
    r.i_oor   = io;
    return r;
  endfunction

  function automatic point_t random_point();
    point_t      p;
    logic [95:0] noise;
    int unsigned pick;
    longint      zw, iw, zt, it;
    noise = {$urandom, $urandom, $urandom};
    p     = noise[$bits(point_t)-1:0];
    pick  = $urandom_range(0, 99);
    zw    = (zbin_width == 0) ? 1 : longint'(zbin_width);
    iw    = (ibin_width == 0) ? 1 : longint'(ibin_width);
    if (pick < 25) begin
      p.op = OP_READ;
      case ($urandom_range(0, 5))
        0: ;
        1: begin
          p.tbl = TBL_TOTALS;
          p.idx = 10'($urandom_range(0, 4));
        end
        2: begin
          p.tbl = TBL_ZHIST;
          p.idx = 10'(last_zidx);
        end
        3: begin
          p.tbl = TBL_IHIST;
          p.idx = 10'(last_ibin);
        end
        4: begin
          p.tbl = TBL_RETURN;
          p.idx = 10'($urandom_range(0, 16));
        end
        default: begin
          p.tbl = TBL_CLASS;
          p.idx = 10'($urandom_range(0, 256));
        end
      endcase
    end else if (pick < 35) begin
      p.op = OP_ADD;
      {p.withheld, p.rejected, p.in_buffer} = 3'($urandom_range(1, 7));
    end else begin
      p.op = OP_ADD;
      {p.withheld, p.rejected, p.in_buffer} = 3'b000;
      if ($urandom_range(0, 2) == 0) p.num_rets = 4'd1;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        // Aim at a bin inside the elevation table, at a random offset across its width.
        zt = (longint'(zfirst) + longint'($urandom_range(0, Z_BINS - 1))) * zw
             + longint'($urandom_range(0, 32'(zw))) - zw / 2;
        if (zt >= -64'sd2147483648 && zt <= 64'sd2147483647) p.z_mm = 32'(zt);
      end else if (pick < 75) begin
        p.z_mm = 32'($urandom_range(0, 10000)) - 32'd5000;
      end
      if ($urandom_range(0, 9) < 7) begin
        it = longint'($urandom_range(0, INTENSITY_BINS - 1)) * iw
             + longint'($urandom_range(0, 32'(iw))) - iw / 2;
        if (it >= 0 && it <= 65535) p.inten = 16'(it);
      end
    end
    return p;
  endfunction

  task automatic load_config(input logic [19:0] zw, input logic [15:0] iw,
                             input logic signed [31:0] zf);
    logic [31:0] junk;
    junk = $urandom;
    // Bits past each width register's width carry noise and must be ignored.
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_Z_WIDTH;
    cfg_data_i  <= {junk[31:20], zw};
    @(posedge clk_i);
    cfg_index_i <= CFG_I_WIDTH;
    cfg_data_i  <= {junk[31:16], iw};
    @(posedge clk_i);
    cfg_index_i <= CFG_Z_FIRST;
    cfg_data_i  <= zf;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    zbin_width = zw;
    ibin_width = iw;
    zfirst     = zf;
  endtask

  task automatic push_item(input point_t p, input logic typed, input stats_out_t want);
    stats_out_t predicted;
    if (!quiet && $urandom_range(0, 59) == 0) begin
      in_valid_i <= 1'b0;
      wait (stats_due.size() == 0);
      @(posedge clk_i);
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    operation_i         <= p.op;
    withheld_i          <= p.withheld;
    rejected_i          <= p.rejected;
    in_buffer_i         <= p.in_buffer;
    return_number_i     <= p.ret_num;
    number_of_returns_i <= p.num_rets;
    classification_i    <= p.cls;
    z_mm_i              <= p.z_mm;
    intensity_i         <= p.inten;
    read_table_i        <= p.tbl;
    read_index_i        <= p.idx;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predicted = tally_point(p);
    stats_due.insert(stats_due.size(), typed ? want : predicted);
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] seen);
    $display("%0t: %s expected %0h got %0h", $time, what, want, seen);
    mismatch_count++;
  endtask

  // Result side: check every transfer and stall in random bursts.
  initial begin
    int         stall_left;
    stats_out_t seen, want;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i) begin
        seen = {counted_o, z_bin_o, intensity_bin_o, z_out_of_range_o,
                intensity_out_of_range_o, read_value_o};
        if (stats_due.size() == 0) begin
          $display("%0t: unexpected result, expected none got %0h", $time, seen);
          mismatch_count++;
        end else begin
          want = stats_due.pop_front();
          if (seen.counted !== want.counted) flag_mismatch("counted", want.counted, seen.counted);
          if (seen.z_bin !== want.z_bin) flag_mismatch("z_bin", want.z_bin, seen.z_bin);
          if (seen.i_bin !== want.i_bin) flag_mismatch("intensity_bin", want.i_bin, seen.i_bin);
          if (seen.z_oor !== want.z_oor) flag_mismatch("z_out_of_range", want.z_oor, seen.z_oor);
          if (seen.i_oor !== want.i_oor) begin
            flag_mismatch("intensity_out_of_range", want.i_oor, seen.i_oor);
          end
          if (seen.value !== want.value) flag_mismatch("read_value", want.value, seen.value);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    dir_row_t rows [$];
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, run with the reset configuration.
    rows = '{
      '{read_pt(TBL_TOTALS, TOT_POINTS), 1'b1, '0},
      '{read_pt(TBL_ZHIST, 10'd1023), 1'b1, '0},
      '{read_pt(TBL_UNMAPPED, 10'd0), 1'b1, '0},
      '{add_pt(1, 0, 0, 1, 1, 2, 1000, 25), 1'b1, '0},
      '{add_pt(0, 1, 0, 1, 1, 2, 1000, 25), 1'b1, '0},
      '{add_pt(0, 0, 1, 1, 1, 2, 1000, 25), 1'b1, '0},
      '{add_pt(0, 0, 0, 1, 1, 2, 0, 0), 1'b1, kept(0, 0, 0, 0)},
      '{add_pt(0, 0, 0, 2, 3, 6, 1000, 25), 1'b1, kept(1, 1, 0, 0)},
      '{add_pt(0, 0, 0, 3, 3, 6, -1000, 24), 1'b1, kept(-1, 0, 1, 0)},
      '{add_pt(0, 0, 0, 15, 15, 255, 32'sh7FFF_FFFF, 16'hFFFF), 1'b1,
        kept(32'sd1073742, 16'd1311, 1, 1)},
      '{add_pt(0, 0, 0, 0, 0, 0, 32'sh8000_0000, 0), 1'b1,
        kept(-32'sd1073742, 0, 1, 0)},
      '{add_pt(0, 0, 0, 1, 1, 2, 2999, 74), 1'b0, '0},
      '{add_pt(0, 0, 0, 1, 2, 9, 3000, 75), 1'b0, '0},
      '{add_pt(0, 0, 0, 4, 5, 17, -3000, 51175), 1'b0, '0},
      '{add_pt(0, 0, 0, 5, 5, 17, 2046999, 51174), 1'b0, '0},
      '{read_pt(TBL_TOTALS, TOT_SINGLE), 1'b0, '0},
      '{read_pt(TBL_TOTALS, TOT_Z_OOR), 1'b0, '0},
      '{read_pt(TBL_TOTALS, TOT_I_OOR), 1'b0, '0},
      '{read_pt(TBL_TOTALS, TOT_PAST_END), 1'b1, '0},
      '{read_pt(TBL_RETURN, 10'd15), 1'b0, '0},
      '{read_pt(TBL_RETURN, 10'd16), 1'b1, '0},
      '{read_pt(TBL_CLASS, 10'd255), 1'b0, '0},
      '{read_pt(TBL_ZHIST, 10'd1023), 1'b0, '0},
      '{read_pt(TBL_IHIST, 10'd1023), 1'b0, '0},
      '{read_pt(TBL_IHIST, 10'd0), 1'b0, '0}
    };
    foreach (rows[n]) push_item(rows[n].pt, rows[n].typed, rows[n].want);
    in_valid_i <= 1'b0;

    // Random phases; the configuration changes only once all results are in.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait (stats_due.size() == 0);
      quiet = (ph == PHASES - 1);
      case (ph)
        0: load_config(20'd1, 16'd1, -32'sd512);
        1: load_config(20'd0, 16'd0, 32'sh8000_0000);
        2: load_config(20'hFFFFF, 16'hFFFF, 32'sh7FFF_FFFF);
        3: load_config(20'($urandom_range(1, 5000)), 16'($urandom_range(1, 300)),
                       32'($urandom_range(0, 4000)) - 32'd2000);
        4: load_config(20'd7, 16'd3, -32'sd300);
        default: load_config(20'd2000, 16'd50, 32'($urandom_range(0, 20)) - 32'd10);
      endcase
      repeat (RUN_ITEMS) push_item(random_point(), 1'b0, '0);
      in_valid_i <= 1'b0;
    end

    wait (stats_due.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
